>>> design/tlev_pkg.sv
// ============================================================================
// tlev_pkg
// Shared types and constants for the TCP loss-emulation verdict block.
// ============================================================================
package tlev_pkg;

    // Field widths fixed by the interface.
    localparam int SEQ_W       = 32;
    localparam int CFG_W       = 16;
    localparam int WINDOW_W    = 17;
    localparam int DROP_OUT_W  = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Default counter width.
    localparam int COUNT_WIDTH_DEF = 16;

    // Register reset values.
    localparam logic [CFG_W-1:0] ACCEPT_CAP_RST = 16'd500;
    localparam logic [CFG_W-1:0] DROP_INDEX_RST = 16'd10000;

    // Register selects, taken from address bit 2 (word-aligned map).
    localparam logic REG_ACCEPT_CAP = 1'b0;
    localparam logic REG_DROP_INDEX = 1'b1;

    // Verdict codes.
    localparam logic VERDICT_ACCEPT = 1'b0;
    localparam logic VERDICT_DROP   = 1'b1;

    // One result item.
    typedef struct packed {
        logic                  verdict;
        logic                  probe_done;
        logic [WINDOW_W-1:0]   window_total;
        logic [DROP_OUT_W-1:0] dropped_total;
    } t_result;

endpackage

>>> design/tcp_loss_emulation_verdict.sv
// ============================================================================
// tcp_loss_emulation_verdict
// A result is registered in the output register, or in the skid entry
// while the output is stalled. Throughput: one request per cycle while the
// skid entry is free; the only loop is the counter and compare update in the
// verdict core. A two-entry output stage (result register plus skid) keeps
// input flowing while a result waits. Synchronous active-low reset restores
// the register defaults and clears all probe state and output valids.
// ============================================================================
module tcp_loss_emulation_verdict #(
    parameter int COUNT_WIDTH = tlev_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlev_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tlev_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tlev_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [tlev_pkg::SEQ_W-1:0]        i_seq_number,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_verdict,
    output logic                              o_probe_done,
    output logic [tlev_pkg::WINDOW_W-1:0]     o_window_total,
    output logic [tlev_pkg::DROP_OUT_W-1:0]   o_dropped_total
);

    logic [tlev_pkg::CFG_W-1:0] r_accept_cap;
    logic [tlev_pkg::CFG_W-1:0] r_drop_index;
    logic                       cfg_write;
    logic                       in_accept;
    logic                       out_ready;
    tlev_pkg::t_result          core_result;
    tlev_pkg::t_result          r_out;
    tlev_pkg::t_result          r_skid;
    logic                       r_out_valid;
    logic                       r_skid_valid;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_cap <= tlev_pkg::ACCEPT_CAP_RST;
            r_drop_index <= tlev_pkg::DROP_INDEX_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                tlev_pkg::REG_ACCEPT_CAP: r_accept_cap <= pwdata[tlev_pkg::CFG_W-1:0];
                tlev_pkg::REG_DROP_INDEX: r_drop_index <= pwdata[tlev_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (paddr[2])
            tlev_pkg::REG_ACCEPT_CAP: prdata = tlev_pkg::APB_DATA_W'(r_accept_cap);
            tlev_pkg::REG_DROP_INDEX: prdata = tlev_pkg::APB_DATA_W'(r_drop_index);
            default:                  prdata = '0;
        endcase
    end

    // Input handshake: stall only while the skid entry is occupied.
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;

    tlev_verdict_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_seq        (i_seq_number),
        .i_accept_cap (r_accept_cap),
        .i_drop_index (r_drop_index),
        .o_result     (core_result)
    );

    // Output register with a skid entry behind it.
    assign out_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
                if (in_accept) begin
                    r_out <= core_result;
                end
            end
        end else if (in_accept) begin
            r_skid       <= core_result;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_verdict       = r_out.verdict;
    assign o_probe_done    = r_out.probe_done;
    assign o_window_total  = r_out.window_total;
    assign o_dropped_total = r_out.dropped_total;

endmodule

>>> design/tlev_verdict_core.sv
// ============================================================================
// tlev_verdict_core
// Per-packet decision logic and probe state. The verdict and the next state
// are worked out in one pass from the arriving sequence number; the state
// registers update at the edge at which the request is accepted.
// ============================================================================
module tlev_verdict_core #(
    parameter int COUNT_WIDTH = tlev_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [tlev_pkg::SEQ_W-1:0]   i_seq,
    input  logic [tlev_pkg::CFG_W-1:0]   i_accept_cap,
    input  logic [tlev_pkg::CFG_W-1:0]   i_drop_index,
    output tlev_pkg::t_result            o_result
);

    // Compare width covers both the counters and the 16-bit registers.
    localparam int CMP_W = (COUNT_WIDTH > tlev_pkg::CFG_W) ? COUNT_WIDTH : tlev_pkg::CFG_W;
    // Sum width keeps the carry and reaches the window field width.
    localparam int SUM_W = ((COUNT_WIDTH + 1) > tlev_pkg::WINDOW_W) ?
                           (COUNT_WIDTH + 1) : tlev_pkg::WINDOW_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0]        r_accept_count, n_accept_count;
    logic [COUNT_WIDTH-1:0]        r_drop_count,   n_drop_count;
    logic [tlev_pkg::SEQ_W-1:0]    r_first_seq,    n_first_seq;
    logic                          r_pending,      n_pending;
    logic [tlev_pkg::SEQ_W-1:0]    r_retx_seq,     n_retx_seq;
    logic                          r_done,         n_done;
    logic [tlev_pkg::WINDOW_W-1:0] r_window,       n_window;

    logic                          verdict;
    logic [CMP_W-1:0]              accept_ext;
    logic [CMP_W-1:0]              drop_wide;
    logic [SUM_W-1:0]              window_sum;

    assign accept_ext = CMP_W'(r_accept_count);
    assign drop_wide  = CMP_W'(n_drop_count);
    assign window_sum = SUM_W'(r_accept_count) + SUM_W'(r_drop_count);

    // Decision and next state for the arriving packet.
    always_comb begin
        n_accept_count = r_accept_count;
        n_drop_count   = r_drop_count;
        n_first_seq    = r_first_seq;
        n_pending      = r_pending;
        n_retx_seq     = r_retx_seq;
        n_done         = r_done;
        n_window       = r_window;
        verdict        = tlev_pkg::VERDICT_ACCEPT;

        if (i_seq == r_retx_seq) begin
            // Retransmission of the emulated loss: accepted, nothing changes.
            verdict = tlev_pkg::VERDICT_ACCEPT;
        end else if (accept_ext < CMP_W'(i_accept_cap)) begin
            // Accept phase, with one emulated loss at the configured index.
            if (r_accept_count != COUNT_MAX) begin
                n_accept_count = r_accept_count + 1'b1;
            end
            if (accept_ext == CMP_W'(i_drop_index)) begin
                n_retx_seq = i_seq;
                verdict    = tlev_pkg::VERDICT_DROP;
            end
        end else if (!r_pending && (i_seq == r_first_seq)) begin
            // First drop-phase segment came back: latch the window.
            n_window = window_sum[tlev_pkg::WINDOW_W-1:0];
            n_done   = 1'b1;
            verdict  = tlev_pkg::VERDICT_ACCEPT;
        end else begin
            // Drop phase: capture the first dropped sequence, count drops.
            if (r_pending) begin
                n_pending   = 1'b0;
                n_first_seq = i_seq;
            end
            if (r_drop_count != COUNT_MAX) begin
                n_drop_count = r_drop_count + 1'b1;
            end
            verdict = tlev_pkg::VERDICT_DROP;
        end
    end

    // Probe state, updated once per accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_count <= '0;
            r_drop_count   <= '0;
            r_first_seq    <= '0;
            r_pending      <= 1'b1;
            r_retx_seq     <= '0;
            r_done         <= 1'b0;
            r_window       <= '0;
        end else if (i_accept) begin
            r_accept_count <= n_accept_count;
            r_drop_count   <= n_drop_count;
            r_first_seq    <= n_first_seq;
            r_pending      <= n_pending;
            r_retx_seq     <= n_retx_seq;
            r_done         <= n_done;
            r_window       <= n_window;
        end
    end

    // Result fields reflect the state after this packet.
    always_comb begin
        o_result.verdict       = verdict;
        o_result.probe_done    = n_done;
        o_result.window_total  = n_window;
        o_result.dropped_total = drop_wide[tlev_pkg::DROP_OUT_W-1:0];
    end

endmodule

>>> design/tlev_checker.sv
// ============================================================================
// tlev_checker
// Port-level checks on the verdict block, attached to the top level by bind.
// ============================================================================
module tlev_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_verdict,
    input logic                              o_probe_done,
    input logic [tlev_pkg::WINDOW_W-1:0]     o_window_total,
    input logic [tlev_pkg::DROP_OUT_W-1:0]   o_dropped_total
);

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // The window total is only latched when the probe completes.
    a_window_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_probe_done |-> o_window_total == '0)
        else $error("window total reported before probe done");

    // Input is held off only while a result is waiting downstream.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no pending result");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_verdict)
            && $stable(o_probe_done) && $stable(o_window_total)
            && $stable(o_dropped_total))
        else $error("stalled result changed");

endmodule

bind tcp_loss_emulation_verdict tlev_checker u_tlev_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_verdict       (o_verdict),
    .o_probe_done    (o_probe_done),
    .o_window_total  (o_window_total),
    .o_dropped_total (o_dropped_total)
);
